[hw/rtl/bccs_pkg.sv]
package bccs_pkg;

	localparam int ST_W   = 16;
	localparam int IDX_W  = 25;
	localparam int HIST_W = 16;

	localparam int PORT_ST_W   = 15;
	localparam int PORT_CNT_W  = 48;
	localparam int PORT_PROB_W = 16;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_LOAD = 2'd0;
	localparam func_t FUNC_BIT  = 2'd1;
	localparam func_t FUNC_READ = 2'd2;
	localparam func_t FUNC_NOP  = 2'd3;

	typedef struct packed {
		func_t            op;
		logic             data_bit;
		logic [ST_W-1:0]  nz;
		logic [ST_W-1:0]  no;
		logic [ST_W-1:0]  arg;
		logic             full;
		logic [IDX_W-1:0] idx;
	} cmd_t;

endpackage

[hw/rtl/bccs_front.sv]
module bccs_front #(
	parameter int STATE_BITS   = 15,
	parameter int HISTORY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               busy,
	output logic                               full,
	input  bccs_pkg::func_t                    func,
	input  logic                               data_bit,
	input  logic [bccs_pkg::PORT_ST_W-1:0]     next_on_zero,
	input  logic [bccs_pkg::PORT_ST_W-1:0]     next_on_one,
	input  logic [bccs_pkg::PORT_ST_W-1:0]     query_state,
	input  logic                               deq,
	output logic                               cmd_valid,
	output bccs_pkg::cmd_t                     cmd
);

	localparam int NS = 1 << STATE_BITS;
	localparam logic [bccs_pkg::ST_W-1:0] SMASK =
		bccs_pkg::ST_W'((32'd1 << STATE_BITS) - 32'd1);
	localparam logic [bccs_pkg::HIST_W-1:0] HMASK =
		bccs_pkg::HIST_W'((32'd1 << HISTORY_BITS) - 32'd1);

	logic [STATE_BITS:0]            loaded_q;
	logic [bccs_pkg::HIST_W-1:0]    hist_q;
	logic [8:0]                     pb_q;
	bccs_pkg::cmd_t                 qmem_q [2];
	logic                           wp_q, rp_q;
	logic [1:0]                     cnt_q;

	logic                           acc, enq, ld_full;
	logic [3:0]                     k;
	logic [bccs_pkg::IDX_W-1:0]     base, raw;
	logic [8:0]                     pb_nx;
	bccs_pkg::cmd_t                 c;

	assign full      = busy || (cnt_q == 2'd2);
	assign acc       = push && !full;
	assign enq       = acc && (func != bccs_pkg::FUNC_NOP);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = qmem_q[rp_q];
	assign ld_full   = (loaded_q == (STATE_BITS+1)'(NS));
	assign pb_nx     = {pb_q[7:0], data_bit};

	always_comb begin
		k = 4'd0;
		for (int i = 0; i < 9; i++) begin
			if (pb_q[i]) k = 4'(i);
		end
		base = bccs_pkg::IDX_W'((32'd1 << HISTORY_BITS) | 32'(hist_q & HMASK));
		raw  = (base << k) | bccs_pkg::IDX_W'(pb_q ^ (9'd1 << k));
	end

	always_comb begin
		c          = '0;
		c.op       = func;
		c.data_bit = data_bit;
		c.nz       = bccs_pkg::ST_W'(next_on_zero) & SMASK;
		c.no       = bccs_pkg::ST_W'(next_on_one) & SMASK;
		c.idx      = raw;
		unique case (func)
			bccs_pkg::FUNC_LOAD: begin
				c.full = ld_full;
				c.arg  = ld_full ? '0 : bccs_pkg::ST_W'(loaded_q[STATE_BITS-1:0]);
			end
			bccs_pkg::FUNC_READ: c.arg = bccs_pkg::ST_W'(query_state) & SMASK;
			default: c.arg = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			hist_q   <= '0;
			pb_q     <= 9'd1;
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (acc && func == bccs_pkg::FUNC_LOAD && !ld_full) loaded_q <= loaded_q + 1'b1;
			if (acc && func == bccs_pkg::FUNC_BIT) begin
				if (pb_nx[8]) begin
					hist_q <= ((hist_q << 8) | bccs_pkg::HIST_W'(pb_nx[7:0])) & HMASK;
					pb_q   <= 9'd1;
				end else begin
					pb_q <= pb_nx;
				end
			end
			if (enq) wp_q <= !wp_q;
			if (deq && cmd_valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(enq) - 2'(deq && cmd_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) qmem_q[wp_q] <= c;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_marker: assert property (@(posedge clk) disable iff (!arst_n) pb_q != 9'd0 && !pb_q[8])
		else $error("partial byte lost its marker");

endmodule

[hw/rtl/bccs_div.sv]
module bccs_div #(
	parameter int W = 49,
	parameter int P = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] z,
	input  logic [W-1:0] t,
	output logic         done,
	output logic [P:0]   q
);

	localparam int NW = $clog2(P + 1);

	logic         busy_q, done_q;
	logic [NW-1:0] n_q;
	logic [W-1:0] r_q, t_q;
	logic [P:0]   q_q;
	logic [W-1:0] d;

	assign d    = t_q - r_q;
	assign done = done_q;
	assign q    = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= busy_q && (n_q == NW'(1));
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= NW'(P);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == NW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= t;
			if (z >= t) begin
				q_q <= (P+1)'(1);
				r_q <= z - t;
			end else begin
				q_q <= '0;
				r_q <= z;
			end
		end else if (busy_q) begin
			if (r_q >= d) begin
				r_q <= r_q - d;
				q_q <= {q_q[P-1:0], 1'b1};
			end else begin
				r_q <= r_q << 1;
				q_q <= {q_q[P-1:0], 1'b0};
			end
		end
	end

endmodule

[hw/rtl/bccs_back.sv]
module bccs_back #(
	parameter int STATE_BITS      = 15,
	parameter int COUNT_BITS      = 48,
	parameter int PROB_SCALE_BITS = 15,
	parameter int CONTEXT_ENTRIES = 16777216
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  bccs_pkg::cmd_t                       cmd,
	output logic                                 deq,
	output logic                                 busy,
	input  logic                                 pop,
	output logic                                 empty,
	output logic                                 kind,
	output logic [bccs_pkg::PORT_ST_W-1:0]       assigned_index,
	output logic                                 table_full,
	output logic [bccs_pkg::PORT_CNT_W-1:0]      zero_count,
	output logic [bccs_pkg::PORT_CNT_W-1:0]      one_count,
	output logic [bccs_pkg::PORT_PROB_W-1:0]     zero_probability
);

	localparam int SB    = STATE_BITS;
	localparam int C     = COUNT_BITS;
	localparam int NS    = 1 << SB;
	localparam int CTXW  = $clog2(CONTEXT_ENTRIES);
	localparam bit POW2  = ((1 << CTXW) == CONTEXT_ENTRIES);
	localparam int SWEEP = (CONTEXT_ENTRIES > NS) ? CONTEXT_ENTRIES : NS;
	localparam int CLRW  = $clog2(SWEEP);
	localparam int XW    = bccs_pkg::IDX_W;
	localparam int RS    = XW - CTXW + 1;
	localparam int JW    = $clog2(RS);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RED  = 4'd2;
	localparam logic [3:0] ST_CTX  = 4'd3;
	localparam logic [3:0] ST_TR   = 4'd4;
	localparam logic [3:0] ST_UPD  = 4'd5;
	localparam logic [3:0] ST_QRD  = 4'd6;
	localparam logic [3:0] ST_SUM  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;

	logic [SB-1:0]   ctx_mem [CONTEXT_ENTRIES];
	logic [2*SB-1:0] tr_mem  [NS];
	logic [C-1:0]    zc_mem  [NS];
	logic [C-1:0]    oc_mem  [NS];

	logic [3:0]      state_q;
	logic [CLRW-1:0] clr_q;
	bccs_pkg::cmd_t  cmd_q;
	logic [XW-1:0]   x_q;
	logic [JW-1:0]   j_q;
	logic [CTXW-1:0] idx_q;
	logic [SB-1:0]   ctx_rd_q, s_q;
	logic [2*SB-1:0] tr_rd_q;
	logic [C-1:0]    zc_rd_q, oc_rd_q;
	logic [SB:0]     lb_q;
	logic            res_valid_q, res_kind_q, res_full_q;
	logic [bccs_pkg::PORT_ST_W-1:0]   res_idx_q;
	logic [bccs_pkg::PORT_CNT_W-1:0]  res_zc_q, res_oc_q;
	logic [bccs_pkg::PORT_PROB_W-1:0] res_p_q;

	logic            clearing, ctx_we, cnt_clr, upd;
	logic [CTXW-1:0] ctx_wa;
	logic [SB-1:0]   ctx_wd, nxt, cnt_addr, cnt_wa;
	logic [XW:0]     red_sub;
	logic [XW-1:0]   x_nx;
	logic [C:0]      sum;
	logic [C:0]      dz, dt;
	logic            div_start, div_done;
	logic [PROB_SCALE_BITS:0] div_q;
	logic [bccs_pkg::PORT_PROB_W-1:0] prob;

	assign clearing = (state_q == ST_CLR);
	assign busy     = clearing;
	assign upd      = (state_q == ST_UPD);
	assign cnt_clr  = clearing && (32'(clr_q) < NS);
	assign ctx_we   = (clearing && (32'(clr_q) < CONTEXT_ENTRIES)) || upd;
	assign ctx_wa   = clearing ? clr_q[CTXW-1:0] : idx_q;
	assign ctx_wd   = clearing ? '0 : nxt;
	assign cnt_wa   = clearing ? clr_q[SB-1:0] : s_q;
	assign cnt_addr = (state_q == ST_TR) ? ctx_rd_q : cmd_q.arg[SB-1:0];
	assign deq      = (state_q == ST_IDLE) && cmd_valid &&
	                  (cmd.op == bccs_pkg::FUNC_BIT || !res_valid_q);

	always_comb begin
		if ((SB+1)'(s_q) < lb_q)
			nxt = cmd_q.data_bit ? tr_rd_q[2*SB-1:SB] : tr_rd_q[SB-1:0];
		else
			nxt = '0;
	end

	assign red_sub = (XW+1)'(CONTEXT_ENTRIES) << j_q;
	assign x_nx    = ((XW+1)'(x_q) >= red_sub) ? XW'((XW+1)'(x_q) - red_sub) : x_q;

	always_comb begin
		sum = (C+1)'(zc_rd_q) + (C+1)'(oc_rd_q);
		if (C == 64 && sum[C]) begin
			dz = (C+1)'(zc_rd_q >> 1);
			dt = (C+1)'(zc_rd_q >> 1) + (C+1)'(oc_rd_q >> 1);
		end else begin
			dz = (C+1)'(zc_rd_q);
			dt = sum;
		end
	end

	assign div_start = (state_q == ST_SUM) && (sum != '0);
	assign prob = (div_q > (PROB_SCALE_BITS+1)'(17'hFFFF)) ? 16'hFFFF :
	              bccs_pkg::PORT_PROB_W'(div_q);

	bccs_div #(.W(C + 1), .P(PROB_SCALE_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.z     (dz),
		.t     (dt),
		.done  (div_done),
		.q     (div_q)
	);

	always_ff @(posedge clk) begin
		if (ctx_we) ctx_mem[ctx_wa] <= ctx_wd;
		ctx_rd_q <= ctx_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (deq && cmd.op == bccs_pkg::FUNC_LOAD && !cmd.full)
			tr_mem[cmd.arg[SB-1:0]] <= {cmd.no[SB-1:0], cmd.nz[SB-1:0]};
		tr_rd_q <= tr_mem[ctx_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_clr) zc_mem[cnt_wa] <= '0;
		else if (upd && !cmd_q.data_bit)
			zc_mem[cnt_wa] <= (&zc_rd_q) ? zc_rd_q : zc_rd_q + C'(1);
		zc_rd_q <= zc_mem[cnt_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_clr) oc_mem[cnt_wa] <= '0;
		else if (upd && cmd_q.data_bit)
			oc_mem[cnt_wa] <= (&oc_rd_q) ? oc_rd_q : oc_rd_q + C'(1);
		oc_rd_q <= oc_mem[cnt_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			lb_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == SWEEP - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (deq) begin
						unique case (cmd.op)
							bccs_pkg::FUNC_LOAD: begin
								res_valid_q <= 1'b1;
								if (!cmd.full) lb_q <= lb_q + 1'b1;
							end
							bccs_pkg::FUNC_BIT: state_q <= POW2 ? ST_CTX : ST_RED;
							default: state_q <= ST_QRD;
						endcase
					end
				end
				ST_RED:  if (j_q == '0) state_q <= ST_CTX;
				ST_CTX:  state_q <= ST_TR;
				ST_TR:   state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_IDLE;
				ST_QRD:  state_q <= ST_SUM;
				ST_SUM: begin
					if (sum == '0) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			cmd_q <= cmd;
			x_q   <= cmd.idx;
			j_q   <= JW'(RS - 1);
			idx_q <= cmd.idx[CTXW-1:0];
			if (cmd.op == bccs_pkg::FUNC_LOAD) begin
				res_kind_q <= 1'b0;
				res_full_q <= cmd.full;
				res_idx_q  <= cmd.arg[bccs_pkg::PORT_ST_W-1:0];
				res_zc_q   <= '0;
				res_oc_q   <= '0;
				res_p_q    <= '0;
			end
		end
		if (state_q == ST_RED) begin
			x_q   <= x_nx;
			j_q   <= j_q - 1'b1;
			idx_q <= x_nx[CTXW-1:0];
		end
		if (state_q == ST_TR) s_q <= ctx_rd_q;
		if (state_q == ST_SUM) begin
			res_kind_q <= 1'b1;
			res_full_q <= 1'b0;
			res_idx_q  <= '0;
			res_zc_q   <= bccs_pkg::PORT_CNT_W'(zc_rd_q);
			res_oc_q   <= bccs_pkg::PORT_CNT_W'(oc_rd_q);
			res_p_q    <= '0;
		end
		if (state_q == ST_DIV && div_done) res_p_q <= prob;
	end

	assign empty            = !res_valid_q;
	assign kind             = res_kind_q;
	assign assigned_index   = res_idx_q;
	assign table_full       = res_full_q;
	assign zero_count       = res_zc_q;
	assign one_count        = res_oc_q;
	assign zero_probability = res_p_q;

	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !res_valid_q && !deq)
		else $error("activity during clearing pass");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		lb_q <= (SB+1)'(NS))
		else $error("fill count overrun");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside wait state");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pop |=> res_valid_q && $stable(res_kind_q))
		else $error("waiting result overwritten");

endmodule

[hw/rtl/bit_context_counter_state_statistics_top.sv]
// channel   | handshake        | payload
// input     | push / full      | func, data_bit, next_on_zero, next_on_one, query_state
// result    | empty / pop      | kind, assigned_index, table_full, zero_count,
//           |                  | one_count, zero_probability
// A load item is handled in the idle state of the back end; a bit item passes
// a context read, a table and count read and a write-back, after reduction
// steps on the index when CONTEXT_ENTRIES is not a power of two.
// A read item reads both counts, sums them and waits for the divider, or skips
// the divider when both counts are zero.
// After reset a clearing pass over max(CONTEXT_ENTRIES, 2^STATE_BITS) entries
// holds full high.
// A two-item queue parts front and back; a waiting result stalls loads and
// reads but not bit items.
module bit_context_counter_state_statistics_top #(
	parameter int STATE_BITS      = 15,
	parameter int HISTORY_BITS    = 16,
	parameter int COUNT_BITS      = 48,
	parameter int PROB_SCALE_BITS = 15,
	parameter int CONTEXT_ENTRIES = 16777216
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [1:0]                           func,
	input  logic                                 data_bit,
	input  logic [bccs_pkg::PORT_ST_W-1:0]       next_on_zero,
	input  logic [bccs_pkg::PORT_ST_W-1:0]       next_on_one,
	input  logic [bccs_pkg::PORT_ST_W-1:0]       query_state,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 kind,
	output logic [bccs_pkg::PORT_ST_W-1:0]       assigned_index,
	output logic                                 table_full,
	output logic [bccs_pkg::PORT_CNT_W-1:0]      zero_count,
	output logic [bccs_pkg::PORT_CNT_W-1:0]      one_count,
	output logic [bccs_pkg::PORT_PROB_W-1:0]     zero_probability
);

	logic           busy, deq, cmd_valid;
	bccs_pkg::cmd_t cmd;

	bccs_front #(
		.STATE_BITS  (STATE_BITS),
		.HISTORY_BITS(HISTORY_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.busy        (busy),
		.full        (full),
		.func        (func),
		.data_bit    (data_bit),
		.next_on_zero(next_on_zero),
		.next_on_one (next_on_one),
		.query_state (query_state),
		.deq         (deq),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	bccs_back #(
		.STATE_BITS     (STATE_BITS),
		.COUNT_BITS     (COUNT_BITS),
		.PROB_SCALE_BITS(PROB_SCALE_BITS),
		.CONTEXT_ENTRIES(CONTEXT_ENTRIES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.deq             (deq),
		.busy            (busy),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.assigned_index  (assigned_index),
		.table_full      (table_full),
		.zero_count      (zero_count),
		.one_count       (one_count),
		.zero_probability(zero_probability)
	);

endmodule
